### hw/rtl/kcl_pkg.sv
// Shared types, constants and helper functions for the keypad code lock.
// No dependencies; every other file in hw/rtl uses this package.
package kcl_pkg;

  localparam int CodeLength = 6;
  localparam int CntW       = $clog2(CodeLength + 1);

  // Decoded key codes; digits decode to their own value 0..9
  localparam logic [3:0] KeyStar = 4'd10;
  localparam logic [3:0] KeyHash = 4'd11;
  localparam logic [3:0] KeyA    = 4'd12;
  localparam logic [3:0] KeyB    = 4'd13;
  localparam logic [3:0] KeyC    = 4'd14;
  localparam logic [3:0] KeyD    = 4'd15;
  localparam logic [3:0] KeyMaxDigit = 4'd9;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgMaxErrors   = 2'd0,
    CfgLockoutTicks = 2'd1,
    CfgUnlockTicks = 2'd2,
    CfgResetKeyEn  = 2'd3
  } cfg_idx_e;

  typedef logic [CodeLength-1:0][3:0] code_t;

  typedef struct packed {
    logic       op;
    logic [3:0] key_index;
  } kcl_in_t;

  typedef struct packed {
    logic [2:0] lock_mode;
    logic       relay_open;
    logic       green_led;
    logic       red_led;
    logic [3:0] event_code;
    logic [3:0] errors_now;
  } kcl_out_t;

  typedef struct packed {
    logic [3:0]  max_errors;
    logic [15:0] lockout_ticks;
    logic [15:0] unlock_ticks;
    logic        reset_key_enable;
  } kcl_cfg_t;

  // Column-major 4x4 keypad: 1,4,7,*,2,5,8,0,3,6,9,#,A,B,C,D
  function automatic logic [3:0] key_decode(input logic [3:0] idx);
    logic [3:0] k;
    case (idx)
      4'd0:    k = 4'd1;
      4'd1:    k = 4'd4;
      4'd2:    k = 4'd7;
      4'd3:    k = KeyStar;
      4'd4:    k = 4'd2;
      4'd5:    k = 4'd5;
      4'd6:    k = 4'd8;
      4'd7:    k = 4'd0;
      4'd8:    k = 4'd3;
      4'd9:    k = 4'd6;
      4'd10:   k = 4'd9;
      4'd11:   k = KeyHash;
      4'd12:   k = KeyA;
      4'd13:   k = KeyB;
      4'd14:   k = KeyC;
      default: k = KeyD;
    endcase
    return k;
  endfunction

  // Factory code 1 2 3 4 5 6, repeating for longer codes
  function automatic code_t first_code();
    code_t c;
    for (int i = 0; i < CodeLength; i++) begin
      c[i] = 4'((i % 6) + 1);
    end
    return c;
  endfunction

endpackage

### hw/rtl/kcl_in_if.sv
// Valid/ready channel carrying one keypad event or timer tick per beat.
// Depends on kcl_pkg for the payload type.
interface kcl_in_if;
  logic            valid;
  logic            ready;
  kcl_pkg::kcl_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/kcl_out_if.sv
// Valid/ready channel carrying one lock status result per beat.
// Depends on kcl_pkg for the payload type.
interface kcl_out_if;
  logic              valid;
  logic              ready;
  kcl_pkg::kcl_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/kcl_fsm.sv
// Lock state machine: mode, entry buffer, codes, error count and timer.
// Updates on each step strobe and presents the result combinationally.
// Depends on kcl_pkg.
module kcl_fsm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  kcl_pkg::kcl_in_t  item_i,
  input  kcl_pkg::kcl_cfg_t cfg_i,
  output kcl_pkg::kcl_out_t result_o
);

  typedef enum logic [2:0] {
    ModeIdle    = 3'd0,
    ModeEnter   = 3'd1,
    ModeOpen    = 3'd3,
    ModeLockout = 3'd4,
    ModeOld     = 3'd5,
    ModeNew     = 3'd6
  } mode_e;

  typedef enum logic [3:0] {
    EvNone       = 4'd0,
    EvDigit      = 4'd1,
    EvIgnored    = 4'd2,
    EvWrong      = 4'd3,
    EvUnlocked   = 4'd4,
    EvLockout    = 4'd5,
    EvEntryStart = 4'd6,
    EvCancel     = 4'd7,
    EvChangeStart = 4'd8,
    EvOldOk      = 4'd9,
    EvFirstNew   = 4'd10,
    EvChanged    = 4'd11,
    EvRelock     = 4'd12,
    EvErrClear   = 4'd13
  } ev_e;

  localparam logic [1:0] PhaseNone  = 2'd0;
  localparam logic [1:0] PhaseFirst = 2'd1;
  localparam logic [1:0] PhaseSecond = 2'd2;

  localparam int CntW = kcl_pkg::CntW;
  localparam logic [CntW-1:0] FullCnt = CntW'(kcl_pkg::CodeLength);

  mode_e                  mode_q, mode_d;
  kcl_pkg::code_t         entry_q, entry_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  kcl_pkg::code_t         stored_q, stored_d;
  kcl_pkg::code_t         pend_q;
  logic                   pend_we;
  logic [1:0]             phase_q, phase_d;
  logic [3:0]             wrong_q, wrong_d;
  logic [15:0]            timer_q, timer_d;
  ev_e                    ev;
  logic [3:0]             key;
  logic                   match_stored, match_pend, full;
  logic [3:0]             wrong_inc;

  always_comb begin
    mode_d   = mode_q;
    entry_d  = entry_q;
    cnt_d    = cnt_q;
    stored_d = stored_q;
    pend_we  = 1'b0;
    phase_d  = phase_q;
    wrong_d  = wrong_q;
    timer_d  = timer_q;
    ev       = EvNone;

    key          = kcl_pkg::key_decode(item_i.key_index);
    full         = (cnt_q == FullCnt);
    match_stored = full && (entry_q == stored_q);
    match_pend   = full && (entry_q == pend_q);
    wrong_inc    = (wrong_q == 4'd15) ? wrong_q : wrong_q + 4'd1;

    if (item_i.op) begin
      if (mode_q == ModeOpen || mode_q == ModeLockout) begin
        if (timer_q > 16'd1) begin
          timer_d = timer_q - 16'd1;
        end else begin
          timer_d = '0;
          mode_d  = ModeIdle;
          if (mode_q == ModeLockout) begin
            wrong_d = '0;
            ev      = EvErrClear;
          end else begin
            ev = EvRelock;
          end
        end
      end
    end else if (mode_q == ModeLockout) begin
      ev = EvIgnored;
    end else if (key <= kcl_pkg::KeyMaxDigit) begin
      if ((mode_q inside {ModeEnter, ModeOld, ModeNew}) && cnt_q < FullCnt) begin
        for (int i = 0; i < kcl_pkg::CodeLength; i++) begin
          if (cnt_q == CntW'(i)) entry_d[i] = key;
        end
        cnt_d = cnt_q + CntW'(1);
        ev    = EvDigit;
      end
    end else begin
      unique case (key)
        kcl_pkg::KeyHash: begin
          entry_d = '0;
          cnt_d   = '0;
          if (mode_q == ModeEnter) begin
            if (match_stored) begin
              wrong_d = '0;
              mode_d  = ModeOpen;
              timer_d = cfg_i.unlock_ticks;
              ev      = EvUnlocked;
            end else begin
              wrong_d = wrong_inc;
              if (wrong_inc >= cfg_i.max_errors) begin
                mode_d  = ModeLockout;
                timer_d = cfg_i.lockout_ticks;
                ev      = EvLockout;
              end else begin
                mode_d = ModeIdle;
                ev     = EvWrong;
              end
            end
          end else if (mode_q == ModeOld) begin
            if (match_stored) begin
              phase_d = PhaseFirst;
              mode_d  = ModeNew;
              ev      = EvOldOk;
            end else begin
              phase_d = PhaseNone;
              mode_d  = ModeIdle;
              ev      = EvWrong;
            end
          end else if (mode_q == ModeNew) begin
            if (phase_q != PhaseSecond) begin
              if (full) begin
                pend_we = 1'b1;
                phase_d = PhaseSecond;
                ev      = EvFirstNew;
              end else begin
                phase_d = PhaseNone;
                mode_d  = ModeIdle;
                ev      = EvWrong;
              end
            end else begin
              if (match_pend) begin
                stored_d = pend_q;
                ev       = EvChanged;
              end else begin
                ev = EvWrong;
              end
              phase_d = PhaseNone;
              mode_d  = ModeIdle;
            end
          end
        end
        kcl_pkg::KeyStar: begin
          entry_d = '0;
          cnt_d   = '0;
          phase_d = PhaseNone;
          mode_d  = ModeIdle;
          ev      = EvCancel;
        end
        kcl_pkg::KeyA: begin
          if (mode_q == ModeIdle) begin
            mode_d  = ModeEnter;
            entry_d = '0;
            cnt_d   = '0;
            ev      = EvEntryStart;
          end
        end
        kcl_pkg::KeyB: begin
          if (mode_q == ModeOpen) begin
            mode_d  = ModeOld;
            phase_d = PhaseNone;
            entry_d = '0;
            cnt_d   = '0;
            ev      = EvChangeStart;
          end
        end
        kcl_pkg::KeyC: begin
          if (mode_q == ModeOpen) begin
            mode_d = ModeIdle;
            ev     = EvRelock;
          end
        end
        default: begin
          // key D
          if (cfg_i.reset_key_enable) begin
            wrong_d = '0;
            ev      = EvErrClear;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeIdle;
      entry_q  <= '0;
      cnt_q    <= '0;
      stored_q <= kcl_pkg::first_code();
      phase_q  <= PhaseNone;
      wrong_q  <= '0;
      timer_q  <= '0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      entry_q  <= entry_d;
      cnt_q    <= cnt_d;
      stored_q <= stored_d;
      phase_q  <= phase_d;
      wrong_q  <= wrong_d;
      timer_q  <= timer_d;
    end
  end

  // Pending code is plain storage, written only by the first new entry
  always_ff @(posedge clk_i) begin
    if (step_i && pend_we) begin
      pend_q <= entry_q;
    end
  end

  always_comb begin
    result_o.lock_mode  = mode_d;
    result_o.relay_open = (mode_d == ModeOpen);
    result_o.green_led  = (mode_d == ModeOpen);
    result_o.red_led    = (mode_d == ModeLockout);
    result_o.event_code = ev;
    result_o.errors_now = wrong_d;
  end

  a_lockout_keys_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !item_i.op && mode_q == ModeLockout |=> mode_q == ModeLockout)
    else $error("key press left lockout");

  a_wrong_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |=> wrong_q == 4'd0 || wrong_q >= $past(wrong_q))
    else $error("error count dropped without clearing");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("entry count past code length");

  a_phase_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeNew) == (phase_q != PhaseNone))
    else $error("change phase out of step with mode");

endmodule

### hw/rtl/keypad_code_lock_controller.sv
// Top level of the keypad code lock: handshakes, input and result registers,
// configuration registers. Depends on kcl_pkg, kcl_in_if, kcl_out_if, kcl_fsm.
//
//   channel   dir   payload                                         beat when
//   in_ch     in    op, key_index                                   valid & ready
//   out_ch    out   lock_mode, relay_open, green_led, red_led,      valid & ready
//                   event_code, errors_now
//   cfg       in    cfg_idx_i, cfg_data_i                           cfg_we_i
//
// One beat per cycle while out_ch is ready; each beat passes through the input
// register, then the state update into the result register.
// Reset restores the factory code 1 2 3 4 5 6 and state and config defaults at once.
// A stalled result holds the input register; in_ch.ready drops only when both
// the input and result registers are full and the result is not being taken.
module keypad_code_lock_controller (
  input  logic         clk_i,
  input  logic         rst_ni,
  kcl_in_if.sink       in_ch,
  kcl_out_if.source    out_ch,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i
);

  logic              in_vld_q;
  kcl_pkg::kcl_in_t  in_q;
  logic              out_vld_q;
  kcl_pkg::kcl_out_t out_q;
  kcl_pkg::kcl_out_t result;
  kcl_pkg::kcl_cfg_t cfg_q;
  logic              advance;
  logic              step;

  assign advance     = !out_vld_q || out_ch.ready;
  assign step        = in_vld_q && advance;
  assign in_ch.ready = !in_vld_q || step;

  assign out_ch.valid = out_vld_q;
  assign out_ch.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_vld_q <= in_ch.valid;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.ready && in_ch.valid) begin
      in_q <= in_ch.data;
    end
    if (step) begin
      out_q <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_errors       <= 4'd3;
      cfg_q.lockout_ticks    <= 16'd300;
      cfg_q.unlock_ticks     <= 16'd50;
      cfg_q.reset_key_enable <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (kcl_pkg::cfg_idx_e'(cfg_idx_i))
        kcl_pkg::CfgMaxErrors:    cfg_q.max_errors       <= cfg_data_i[3:0];
        kcl_pkg::CfgLockoutTicks: cfg_q.lockout_ticks    <= cfg_data_i;
        kcl_pkg::CfgUnlockTicks:  cfg_q.unlock_ticks     <= cfg_data_i;
        default:                  cfg_q.reset_key_enable <= cfg_data_i[0];
      endcase
    end
  end

  kcl_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

endmodule
